// ===== rtl/tssa_pkg.sv =====
// Shared types, constants and register indexes for the training set size adapter.
`default_nettype none

package tssa_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] THRESHOLD_RST  = 16'd32768;
    localparam logic [15:0] ITER_CHANGE_RST = 16'd10;
    localparam logic [15:0] MAX_EXAMPLES_RST = 16'd1000;
    localparam logic [15:0] INIT_EXAMPLES_RST = 16'd10;
    localparam logic        INIT_LOCAL_RST = 1'b1;
    localparam logic [15:0] FROZEN_RST = 16'd0;
    localparam logic [15:0] COUNTER_TOP = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD     = 3'd0,
        CFG_ITER_CHANGE   = 3'd1,
        CFG_MAX_EXAMPLES  = 3'd2,
        CFG_INIT_EXAMPLES = 3'd3,
        CFG_INIT_LOCAL    = 3'd4,
        CFG_FROZEN        = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_KEEP      = 2'd0,
        ACT_LEAVE     = 2'd1,
        ACT_GROW      = 2'd2,
        ACT_UNTRAINED = 2'd3
    } action_t;

    typedef struct packed {
        logic [15:0] best_fitness;
        logic [15:0] support_vector_count;
        logic [15:0] dataset_size;
        logic        trained;
    } in_t;

    typedef struct packed {
        logic [15:0] class_examples;
        logic        local_mode;
        action_t     action;
        logic        hit_maximum;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RATIO,
        ST_DECIDE,
        ST_MUL,
        ST_GROW,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic untrained;
        logic p_one;
        logic div_ratio;
        logic p_div;
        logic decide;
        logic keep_upd;
        logic leave_local;
        logic div_grow;
        logic grow_upd;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic trained;
        logic sat;
        logic keep;
        logic local_mode;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tssa_div.sv =====
// Restoring divider, one quotient bit per cycle, with preloadable remainder.
`default_nettype none

module tssa_div #(
    parameter int DW = 33,
    parameter int VW = 17,
    parameter int CW = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [VW-1:0] rem_init,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    input  wire logic [CW-1:0] steps,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[DW-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== rtl/tssa_dpath.sv =====
// Datapath: configuration, adapter state, ratio and growth arithmetic, result register.
`default_nettype none

module tssa_dpath #(
    parameter int FRACTION_BITS = tssa_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tssa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tssa_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire tssa_pkg::in_t                   s_data,
    input  wire tssa_pkg::ctrl_cmd_t             cmd,
    output tssa_pkg::dp_stat_t                   stat,
    output tssa_pkg::out_t                       m_data
);

    localparam int FB = FRACTION_BITS;
    localparam int PW = FB + 1;
    localparam int DW = 16 + PW;
    localparam int VW = (PW > 17) ? PW : 17;
    localparam int CW = $clog2(DW + 1);
    localparam logic [PW-1:0] ONE = {1'b1, {FB{1'b0}}};

    logic [15:0] thr_reg;
    logic [15:0] iter_chg_reg;
    logic [15:0] max_reg;
    logic [15:0] init_n_reg;
    logic        init_local_reg;
    logic [15:0] frozen_reg;

    logic [15:0] count_reg;
    logic        local_reg;
    logic [15:0] iter_reg;
    logic [15:0] mode_fit_reg;
    logic [15:0] last_fit_reg;

    tssa_pkg::in_t     in_reg;
    logic [PW-1:0]     p_reg;
    logic [DW-1:0]     prod_reg;
    tssa_pkg::action_t act_reg;
    logic              hit_reg;
    tssa_pkg::out_t    out_reg;

    logic [16:0]    den;
    logic [FB+15:0] t_shift;
    logic [PW-1:0]  t_s;
    logic [PW-1:0]  diff;
    logic [PW-1:0]  grow_den;
    logic [16:0]    d_iter;
    logic [16:0]    d_mode;
    logic [17:0]    d_iter2;
    logic           keep;

    logic           div_start;
    logic [VW-1:0]  div_rem;
    logic [DW-1:0]  div_dvd;
    logic [VW-1:0]  div_dsr;
    logic [CW-1:0]  div_steps;
    logic           div_done;
    logic [DW-1:0]  quo;

    logic           q_hi;
    logic [16:0]    grown;
    logic           hit;

    always_comb begin
        den      = {1'b0, in_reg.dataset_size} + {1'b0, frozen_reg};
        t_shift  = {thr_reg, {FB{1'b0}}} >> 16;
        t_s      = {1'b0, t_shift[FB-1:0]};
        diff     = (p_reg > t_s) ? (p_reg - t_s) : (t_s - p_reg);
        grow_den = ONE - t_s;
        d_iter   = {1'b0, in_reg.best_fitness} - {1'b0, last_fit_reg};
        d_mode   = {1'b0, in_reg.best_fitness} - {1'b0, mode_fit_reg};
        d_iter2  = {d_iter, 1'b0};
        keep     = (iter_reg < iter_chg_reg)
                || ($signed(d_iter2) >= $signed({d_mode[16], d_mode}))
                || (p_reg < t_s)
                || (d_mode == 17'd0);
    end

    always_comb begin
        div_start = cmd.div_ratio | cmd.div_grow;
        if (cmd.div_grow) begin
            div_rem   = '0;
            div_dvd   = prod_reg;
            div_dsr   = VW'(grow_den);
            div_steps = CW'(DW);
        end else begin
            div_rem   = VW'(in_reg.support_vector_count);
            div_dvd   = '0;
            div_dsr   = VW'(den);
            div_steps = CW'(FB);
        end
    end

    tssa_div #(
        .DW (DW),
        .VW (VW),
        .CW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb begin
        q_hi  = |quo[DW-1:16];
        grown = {1'b0, count_reg} + {1'b0, quo[15:0]};
        hit   = q_hi || (grown >= {1'b0, max_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= tssa_pkg::THRESHOLD_RST;
            iter_chg_reg   <= tssa_pkg::ITER_CHANGE_RST;
            max_reg        <= tssa_pkg::MAX_EXAMPLES_RST;
            init_n_reg     <= tssa_pkg::INIT_EXAMPLES_RST;
            init_local_reg <= tssa_pkg::INIT_LOCAL_RST;
            frozen_reg     <= tssa_pkg::FROZEN_RST;
            count_reg      <= tssa_pkg::INIT_EXAMPLES_RST;
            local_reg      <= tssa_pkg::INIT_LOCAL_RST;
            iter_reg       <= '0;
            mode_fit_reg   <= '0;
            last_fit_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (tssa_pkg::cfg_idx_t'(cfg_index))
                    tssa_pkg::CFG_THRESHOLD:    thr_reg <= cfg_wr_data;
                    tssa_pkg::CFG_ITER_CHANGE:  iter_chg_reg <= cfg_wr_data;
                    tssa_pkg::CFG_MAX_EXAMPLES: max_reg <= cfg_wr_data;
                    tssa_pkg::CFG_INIT_EXAMPLES: begin
                        init_n_reg <= cfg_wr_data;
                        count_reg  <= cfg_wr_data;
                    end
                    tssa_pkg::CFG_INIT_LOCAL: begin
                        init_local_reg <= cfg_wr_data[0];
                        local_reg      <= cfg_wr_data[0];
                    end
                    tssa_pkg::CFG_FROZEN:       frozen_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.decide) begin
                last_fit_reg <= in_reg.best_fitness;
            end
            if (cmd.keep_upd && iter_reg != tssa_pkg::COUNTER_TOP) begin
                iter_reg <= iter_reg + 16'd1;
            end
            if (cmd.leave_local) begin
                local_reg <= 1'b0;
            end
            if (cmd.grow_upd) begin
                count_reg    <= hit ? max_reg : grown[15:0];
                mode_fit_reg <= in_reg.best_fitness;
                local_reg    <= 1'b1;
                iter_reg     <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.p_one) begin
            p_reg <= ONE;
        end else if (cmd.p_div) begin
            p_reg <= {1'b0, quo[FB-1:0]};
        end
        if (cmd.decide) begin
            prod_reg <= DW'(count_reg * diff);
        end
        if (cmd.untrained) begin
            act_reg <= tssa_pkg::ACT_UNTRAINED;
            hit_reg <= 1'b0;
        end else if (cmd.keep_upd) begin
            act_reg <= tssa_pkg::ACT_KEEP;
            hit_reg <= 1'b0;
        end else if (cmd.leave_local) begin
            act_reg <= tssa_pkg::ACT_LEAVE;
            hit_reg <= 1'b0;
        end else if (cmd.grow_upd) begin
            act_reg <= tssa_pkg::ACT_GROW;
            hit_reg <= hit;
        end
        if (cmd.out_load) begin
            out_reg.class_examples <= count_reg;
            out_reg.local_mode     <= local_reg;
            out_reg.action         <= act_reg;
            out_reg.hit_maximum    <= hit_reg;
        end
    end

    always_comb begin
        stat.trained    = in_reg.trained;
        stat.sat        = {1'b0, in_reg.support_vector_count} >= den;
        stat.keep       = keep;
        stat.local_mode = local_reg;
        stat.div_done   = div_done;
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ===== rtl/tssa_ctrl.sv =====
// Controller: sequences one report through ratio, decision, growth and result hand-off.
`default_nettype none

module tssa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire tssa_pkg::dp_stat_t stat,
    output tssa_pkg::ctrl_cmd_t     cmd
);

    tssa_pkg::state_t state_reg;
    tssa_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tssa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            tssa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = tssa_pkg::ST_START;
                end
            end
            tssa_pkg::ST_START: begin
                if (!stat.trained) begin
                    cmd.untrained = 1'b1;
                    state_next    = tssa_pkg::ST_FINISH;
                end else if (stat.sat) begin
                    cmd.p_one  = 1'b1;
                    state_next = tssa_pkg::ST_DECIDE;
                end else begin
                    cmd.div_ratio = 1'b1;
                    state_next    = tssa_pkg::ST_RATIO;
                end
            end
            tssa_pkg::ST_RATIO: begin
                if (stat.div_done) begin
                    cmd.p_div  = 1'b1;
                    state_next = tssa_pkg::ST_DECIDE;
                end
            end
            tssa_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.keep) begin
                    cmd.keep_upd = 1'b1;
                    state_next   = tssa_pkg::ST_FINISH;
                end else if (stat.local_mode) begin
                    cmd.leave_local = 1'b1;
                    state_next      = tssa_pkg::ST_FINISH;
                end else begin
                    state_next = tssa_pkg::ST_MUL;
                end
            end
            tssa_pkg::ST_MUL: begin
                cmd.div_grow = 1'b1;
                state_next   = tssa_pkg::ST_GROW;
            end
            tssa_pkg::ST_GROW: begin
                if (stat.div_done) begin
                    cmd.grow_upd = 1'b1;
                    state_next   = tssa_pkg::ST_FINISH;
                end
            end
            tssa_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = tssa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tssa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/training_set_size_adapter.sv =====
// Top level of the training set size adapter: controller plus datapath.
//
// One generation report is handled at a time. Its length is set mostly by the support
// vector ratio division in the shared restoring divider (one quotient bit per cycle); a
// ratio at or above one skips the division. A growth step adds a second division through
// the same divider, which produces all 17 + FRACTION_BITS quotient bits. The result sits
// in an output register, so the next report is taken while the previous result waits.
// Configuration writes land at once; writing an initial register also loads the
// matching state.
`default_nettype none

module training_set_size_adapter #(
    parameter int FRACTION_BITS = tssa_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tssa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tssa_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire tssa_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output tssa_pkg::out_t                        m_data
);

    tssa_pkg::ctrl_cmd_t cmd;
    tssa_pkg::dp_stat_t  stat;

    tssa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tssa_dpath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ===== test/tb_training_set_size_adapter.sv =====
// Testbench for the training set size adapter: randomized reports checked by a scoreboard.
`timescale 1ns / 1ps

module tb_training_set_size_adapter;
    import tssa_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam int T_UP = (FB >= 16) ? FB - 16 : 0;
    localparam int T_DOWN = (FB < 16) ? 16 - FB : 0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam int PHASES = 7;
    localparam int PHASE_REQUESTS = 128;
    localparam int DRAIN_CYCLES = 64;

    class size_adapter_scoreboard;
        logic [15:0] thr, iters, max_n, init_n, frozen;
        logic        init_local;
        logic [15:0] count_n, iter_cnt, mode_fit, last_fit;
        logic        local_m;
        out_t        expected_q[$];
        int          errors;

        function void reset_state();
            thr = THRESHOLD_RST;
            iters = ITER_CHANGE_RST;
            max_n = MAX_EXAMPLES_RST;
            init_n = INIT_EXAMPLES_RST;
            init_local = INIT_LOCAL_RST;
            frozen = FROZEN_RST;
            count_n = INIT_EXAMPLES_RST;
            local_m = INIT_LOCAL_RST;
            iter_cnt = '0;
            mode_fit = '0;
            last_fit = '0;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_THRESHOLD: thr = data;
                CFG_ITER_CHANGE: iters = data;
                CFG_MAX_EXAMPLES: max_n = data;
                CFG_INIT_EXAMPLES: begin
                    init_n = data;
                    count_n = data;
                end
                CFG_INIT_LOCAL: begin
                    init_local = data[0];
                    local_m = data[0];
                end
                CFG_FROZEN: frozen = data;
                default: ;
            endcase
        endfunction

        function void note_request(in_t r);
            logic [63:0] one, t, den, p, diff, grown;
            longint      fv, lv, mv, d_iter, d_mode;
            logic        keep;
            out_t        e;
            one = 64'd1 << FB;
            t = (64'(thr) << T_UP) >> T_DOWN;
            e.hit_maximum = 1'b0;
            if (!r.trained) begin
                e.action = ACT_UNTRAINED;
            end else begin
                den = 64'(r.dataset_size) + 64'(frozen);
                if (den == 0) begin
                    p = one;
                end else begin
                    p = (64'(r.support_vector_count) << FB) / den;
                    if (p > one) p = one;
                end
                fv = 64'(r.best_fitness);
                lv = 64'(last_fit);
                mv = 64'(mode_fit);
                d_iter = fv - lv;
                d_mode = fv - mv;
                keep = (iter_cnt < iters) || (2 * d_iter >= d_mode) || (p < t) || (d_mode == 0);
                if (keep) begin
                    if (iter_cnt != COUNTER_TOP) iter_cnt = iter_cnt + 16'd1;
                    e.action = ACT_KEEP;
                end else if (local_m) begin
                    local_m = 1'b0;
                    e.action = ACT_LEAVE;
                end else begin
                    diff = (p > t) ? p - t : t - p;
                    grown = 64'(count_n) + (64'(count_n) * diff) / (one - t);
                    if (grown < 64'(max_n)) begin
                        count_n = grown[15:0];
                    end else begin
                        count_n = max_n;
                        e.hit_maximum = 1'b1;
                    end
                    mode_fit = r.best_fitness;
                    local_m = 1'b1;
                    iter_cnt = '0;
                    e.action = ACT_GROW;
                end
                last_fit = r.best_fitness;
            end
            e.class_examples = count_n;
            e.local_mode = local_m;
            expected_q.push_back(e);
        endfunction

        function void flag(string what, out_t e, out_t got);
            errors++;
            if (errors <= 10)
                $display("%s: expected n=%0d local=%0b action=%0d hit=%0b,",
                         what, e.class_examples, e.local_mode, e.action, e.hit_maximum,
                         " got n=%0d local=%0b action=%0d hit=%0b",
                         got.class_examples, got.local_mode, got.action, got.hit_maximum);
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (expected_q.size() == 0) begin
                e = '0;
                flag("unexpected result", e, got);
            end else begin
                e = expected_q.pop_front();
                if (got.class_examples !== e.class_examples || got.local_mode !== e.local_mode ||
                    got.action !== e.action || got.hit_maximum !== e.hit_maximum)
                    flag("result mismatch", e, got);
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_t                    s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_t                   m_data;

    size_adapter_scoreboard sb;
    longint cycles = 0;
    bit     tx_steady = 1'b0;
    bit     rx_steady = 1'b0;
    int     rx_hold = 0;

    training_set_size_adapter #(.FRACTION_BITS(FB)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function int gap_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0) rx_steady = ~rx_steady;
        if (rx_steady) begin
            rx_hold = 0;
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_hold = gap_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    function in_t request(logic [15:0] f, logic [15:0] sv, logic [15:0] size, logic tr);
        in_t r;
        r.best_fitness = f;
        r.support_vector_count = sv;
        r.dataset_size = size;
        r.trained = tr;
        return r;
    endfunction

    function in_t random_request();
        in_t         r;
        int          kind;
        logic [63:0] den, sv_min;
        kind = $urandom_range(0, 99);
        r.best_fitness = 16'($urandom);
        r.support_vector_count = 16'($urandom);
        r.dataset_size = 16'($urandom);
        r.trained = 1'b1;
        if (kind < 55) begin
            // drift fitness slowly and hold the ratio at or above threshold
            if ($urandom_range(0, 9) == 0) r.best_fitness = 16'($urandom);
            else if (sb.last_fit > 16'hFFF0) r.best_fitness = 16'($urandom_range(0, 4095));
            else r.best_fitness = sb.last_fit + 16'($urandom_range(0, 3));
            r.dataset_size = 16'($urandom_range(0, 400));
            den = 64'(r.dataset_size) + 64'(sb.frozen);
            if (den != 0) begin
                sv_min = ((64'(sb.thr) * den + 64'hFFFF) >> 16) + 64'($urandom_range(0, 64));
                r.support_vector_count = (sv_min > 64'hFFFF) ? 16'hFFFF : sv_min[15:0];
            end
        end else if (kind < 75) begin
            if ($urandom_range(0, 1) == 1) r.dataset_size = 16'($urandom_range(0, 255));
        end else if (kind < 87) begin
            r.trained = 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: r.dataset_size = '0;
                1: begin
                    r.support_vector_count = 16'hFFFF;
                    r.dataset_size = 16'($urandom_range(0, 15));
                end
                2: r.best_fitness = sb.mode_fit;
                default: r.best_fitness = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            endcase
        end
        return r;
    endfunction

    task send_request(input in_t r);
        int gap;
        gap = 0;
        if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
        if (!tx_steady && $urandom_range(0, 2) == 0) gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.write_register(idx, data);
    endtask

    task configure(input logic [15:0] thr, iters, max_n, init_n, local_word, frozen);
        write_register(CFG_THRESHOLD, thr);
        write_register(CFG_ITER_CHANGE, iters);
        write_register(CFG_MAX_EXAMPLES, max_n);
        write_register(CFG_INIT_EXAMPLES, init_n);
        write_register(CFG_INIT_LOCAL, local_word);
        write_register(CFG_FROZEN, frozen);
        write_register(CFG_SPARE_LO, 16'($urandom));
        write_register(CFG_SPARE_HI, 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_request(request(16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_request(request(16'hFFFF, 16'hFFFF, 16'h0001, 1'b1));
        send_request(request(16'h0000, 16'h0000, 16'hFFFF, 1'b1));
        wait_drained();
        configure(16'd32768, 16'd1, 16'd40, 16'd10, 16'd1, 16'd0);
        for (int f = 100; f <= 107; f++) send_request(request(16'(f), 16'hFFFF, 16'd1, 1'b1));
        send_request(request(16'd107, 16'hFFFF, 16'd1, 1'b1));
        send_request(request(16'd106, 16'hFFFF, 16'd1, 1'b1));
        send_request(request(16'd50, 16'd0, 16'd0, 1'b0));
        send_request(request(16'd0, 16'd0, 16'd10, 1'b1));
        send_request(request(16'd0, 16'd0, 16'd0, 1'b1));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            configure(ph == 1 ? 16'd0 : ph == 2 ? 16'hFFFF : ph == 6 ? 16'd1 : 16'($urandom),
                      ph == 3 ? 16'hFFFF : ph == 4 ? 16'd0 : 16'($urandom_range(1, 4)),
                      ph == 2 ? 16'hFFFF : ph == 5 ? 16'd0 : ph == 1 ? 16'd1
                          : 16'($urandom_range(20, 20000)),
                      ph == 1 ? 16'hFFFF : ph == 4 ? 16'd0 : ph == 2 ? 16'd1
                          : 16'($urandom_range(1, 200)),
                      16'($urandom),
                      ph == 5 ? 16'hFFFF : ph == 2 ? 16'd0
                          : ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom));
            repeat (PHASE_REQUESTS) send_request(random_request());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
